@@ rtl/lbp_pkg.sv @@
// Package for the 3x3 local binary pattern block: sizes, reset values,
// register indexes and the position struct shared by the modules.
// No dependencies.
package lbp_pkg;

   localparam int LBP_MAX_WIDTH  = 1024;
   localparam int LBP_PIXEL_BITS = 8;

   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 12;
   localparam int CSR_DATA_BITS   = 12;
   localparam int CSR_INDEX_BITS  = 1;

   localparam logic [WIDTH_REG_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Where the accepted pixel sits in the frame.
   typedef struct packed {
      logic emit;   // center is an interior pixel, a code is due
      logic last;   // final code of the frame
   } lbp_pos_type;

endpackage

@@ rtl/lbp_3x3_raster.sv @@
// Top level of the 3x3 local binary pattern block over a raster pixel stream.
// Instantiates lbp_raster_ctl, lbp_line_ram and lbp_window; uses lbp_pkg.
//
// The block takes one grayscale pixel per req_ transfer in raster order and
// gives one 8-bit LBP code per rsp_ transfer for every interior pixel, so a
// frame yields (height-2)x(width-2) codes; rsp_tlast marks the last code of a
// frame. Code bit 7 is top-left, then clockwise (6 top, 5 top-right, 4 right,
// 3 bottom-right, 2 bottom, 1 bottom-left), bit 0 is left; a bit is 1 where
// the neighbor is greater than or equal to the center. A code is formed in
// stage 1 and held in the output register after the transfer of the pixel
// below and right of its center. One pixel is taken per clock unless a full
// output stalls stage 1: the line RAM is read at the accepted column, and
// stage 1 writes back to another column. The two previous lines live in one RAM
// of MAX_WIDTH words; it is never cleared, as the first two lines of each
// frame fill it before any code reads it. Width and height are set through
// the csr_ port (index 0 frame_width, clamped to 3..MAX_WIDTH; index 1
// frame_height, clamped to at least 3) and take effect at once; write them
// only between frames. Only the low PIXEL_BITS bits of req_tdata are used.
module lbp_3x3_raster
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH  = LBP_MAX_WIDTH,
   parameter int PIXEL_BITS = LBP_PIXEL_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   // configuration write port
   input  logic                       csr_we,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   // pixel input
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] pixel_value
   // code output
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] lbp_code
   output logic                       rsp_tlast    // frame_last
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic                    req_accept;
   logic [PIXEL_BITS-1:0]   pix;
   logic [AW-1:0]           col;
   lbp_pos_type             pos;

   logic [2*PIXEL_BITS-1:0] rd_data;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [2*PIXEL_BITS-1:0] wr_data;

   assign req_accept = req_tvalid && req_tready;

   // pixel bits beyond the 8-bit field read as zero
   generate
      if (PIXEL_BITS <= 8) begin : g_pix_narrow
         assign pix = req_tdata[PIXEL_BITS-1:0];
      end else begin : g_pix_wide
         assign pix = PIXEL_BITS'(req_tdata);
      end
   endgenerate

   // frame size registers and raster position of the pixel in transfer
   lbp_raster_ctl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_accept (req_accept),
      .col       (col),
      .pos       (pos)
   );

   // both previous lines, {older, newer}, read at the column being accepted
   lbp_line_ram #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * PIXEL_BITS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // write-back, held columns, comparison and output register
   lbp_window #(
      .PIXEL_BITS (PIXEL_BITS),
      .ADDR_BITS  (AW)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_pix    (pix),
      .in_addr   (col),
      .in_pos    (pos),
      .in_ready  (req_tready),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_code  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

@@ rtl/lbp_line_ram.sv @@
// Line store RAM: one write port, one read port with registered read data.
// Holds both previous lines side by side in one word. Depends on nothing.
module lbp_line_ram #(
   parameter int DEPTH     = 1024,
   parameter int DATA_BITS = 16
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_BITS-1:0]       rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_BITS-1:0]       wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lbp_raster_ctl.sv @@
// Raster position tracking: frame size registers, column and row counters.
// Uses lbp_pkg for register indexes, reset values and lbp_pos_type.
module lbp_raster_ctl
   import lbp_pkg::*;
#(
   parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          in_accept,
   output logic [$clog2(MAX_WIDTH)-1:0]  col,
   output lbp_pos_type                   pos
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
   localparam int RW = HEIGHT_REG_BITS + 1;

   logic [WIDTH_REG_BITS-1:0]  width_ff;
   logic [HEIGHT_REG_BITS-1:0] height_ff;
   logic [CW-1:0]              col_ff, col_in;
   logic [HEIGHT_REG_BITS-1:0] row_ff, row_in;

   logic [EW-1:0] width_ext, eff_width, col_next;
   logic [HEIGHT_REG_BITS-1:0] eff_height;
   logic [RW-1:0] row_next;
   logic          col_wrap, row_wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp width to 3..MAX_WIDTH, height to at least 3
   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext < EW'(3)) begin
         eff_width = EW'(3);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      eff_height = (height_ff < HEIGHT_REG_BITS'(3)) ? HEIGHT_REG_BITS'(3) : height_ff;
   end

   assign col_next = EW'(col_ff) + EW'(1);
   assign row_next = RW'(row_ff) + RW'(1);
   assign col_wrap = (col_next >= eff_width);
   assign row_wrap = (row_next >= RW'(eff_height));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (in_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[HEIGHT_REG_BITS-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col      = col_ff;
   assign pos.emit = (row_ff >= HEIGHT_REG_BITS'(2)) && (col_ff >= CW'(2));
   assign pos.last = row_wrap && col_wrap;

endmodule

@@ rtl/lbp_window.sv @@
// Window stage: takes the line RAM read data, writes the shifted lines back,
// keeps the two held columns, forms the code and drives the output register.
// Uses lbp_pkg for lbp_pos_type.
module lbp_window
   import lbp_pkg::*;
#(
   parameter int PIXEL_BITS = LBP_PIXEL_BITS,
   parameter int ADDR_BITS  = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_accept,
   input  logic [PIXEL_BITS-1:0]     in_pix,
   input  logic [ADDR_BITS-1:0]      in_addr,
   input  lbp_pos_type               in_pos,
   output logic                      in_ready,
   input  logic [2*PIXEL_BITS-1:0]   rd_data,
   output logic                      wr_en,
   output logic [ADDR_BITS-1:0]      wr_addr,
   output logic [2*PIXEL_BITS-1:0]   wr_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                out_code,
   output logic                      out_last
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [ADDR_BITS-1:0]  s1_addr_ff;
   lbp_pos_type           s1_pos_ff;
   logic                  s1_adv, s1_fire;

   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [PIXEL_BITS-1:0] top, mid, bot, ctr;
   logic [7:0]            code;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_code_ff;
   logic       out_last_ff;

   // stage 1 moves on unless it owes a code and the output register is full and not being taken
   assign s1_adv      = !s1_valid_ff || !s1_pos_ff.emit || !out_valid_ff || out_ready;
   assign s1_fire     = s1_valid_ff && s1_adv;
   assign s1_valid_in = in_accept || (s1_valid_ff && !s1_adv);
   assign in_ready    = s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_pix_ff  <= in_pix;
         s1_addr_ff <= in_addr;
         s1_pos_ff  <= in_pos;
      end
   end

   assign top = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid = rd_data[PIXEL_BITS-1:0];
   assign bot = s1_pix_ff;
   assign ctr = win_ff[1];

   // older line takes the newer one, newer takes the current pixel
   assign wr_en   = s1_fire;
   assign wr_addr = s1_addr_ff;
   assign wr_data = {mid, bot};

   always_comb begin
      code[7] = (win_ff[3] >= ctr);
      code[6] = (win_ff[0] >= ctr);
      code[5] = (top       >= ctr);
      code[4] = (mid       >= ctr);
      code[3] = (bot       >= ctr);
      code[2] = (win_ff[2] >= ctr);
      code[1] = (win_ff[5] >= ctr);
      code[0] = (win_ff[4] >= ctr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= bot;
      end
   end

   always_comb begin
      if (s1_fire && s1_pos_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_pos_ff.emit) begin
         out_code_ff <= code;
         out_last_ff <= s1_pos_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_code  = out_code_ff;
   assign out_last  = out_last_ff;

endmodule
